### hdl/lwqc_pkg.sv
// shared types and constants for the loss window quality classifier
`timescale 1ns / 1ps

package lwqc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 16;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 24;

    // quotient bits of one window mean, one bit per divider step
    localparam int QUOT_W = 8;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_LEN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VIDEO_LEN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_HIGH_TH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_LOW_TH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_VIDEO_HIGH_TH = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_VIDEO_LOW_TH  = 3'd5;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_AUDIO = 2'd2;
    localparam logic [1:0] KIND_VIDEO = 2'd3;

    localparam logic [1:0] LEVEL_HIGH = 2'd0;
    localparam logic [1:0] LEVEL_LOW  = 2'd1;
    localparam logic [1:0] LEVEL_GOOD = 2'd2;

    typedef struct packed {
        logic load_item;
        logic mem_read;
        logic push_write;
        logic div_start;
        logic div_sel;
        logic div_step;
        logic save_audio;
        logic save_video;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] item_kind;
        logic       last;
        logic       sel_len_zero;
        logic       sel_full;
        logic       both_full;
    } dp_status_t;

endpackage

### hdl/loss_window_quality_classifier_unit.sv
// top level of the loss window quality classifier
// one word at a time: a full window first reads its oldest sample, then the write replaces it
// packet end with both windows full: result from two 8-step serial divisions
// (audio then video) through one shared divider
// next word taken the cycle after the result is loaded; output register holds it meanwhile
// aresetn synchronous active low: window lengths 1, windows empty, level good, no result
`timescale 1ns / 1ps

module loss_window_quality_classifier_unit import lwqc_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // reported loss, publisher loss
    input  logic [S_USER_W-1:0]   s_tuser,   // kind
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // quality_level, level_changed, recent_losses,
                                             // audio_average, video_average, zero pad
);

    dp_cmd_t    cmd;
    dp_status_t st;

    lwqc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lwqc_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .st        (st),
        .m_tdata   (m_tdata)
    );

    a_loss_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == ((m_tdata[11:4] != 8'd0) || (m_tdata[19:12] != 8'd0))))
        else $error("recent loss flag disagrees with averages");

    a_level_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == LEVEL_HIGH || m_tdata[1:0] == LEVEL_LOW
                      || m_tdata[1:0] == LEVEL_GOOD))
        else $error("invalid quality level on output");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in work");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_item, cmd.mem_read, cmd.push_write, cmd.div_step,
                  cmd.div_start, cmd.load_result}))
        else $error("conflicting datapath commands");

endmodule

### hdl/lwqc_ctrl.sv
// controller state machine: push sequencing, packet end checks, divider steps, output
`timescale 1ns / 1ps

module lwqc_ctrl import lwqc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_WRITE,
        ST_CHECK,
        ST_DIV_A,
        ST_SWITCH,
        ST_DIV_V,
        ST_SAVE,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic                seen_reg, seen_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        seen_next     = seen_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (st.item_kind != KIND_NONE) begin
                    seen_next = 1'b1;
                end
                state_next = ST_CHECK;
                if ((st.item_kind == KIND_AUDIO || st.item_kind == KIND_VIDEO)
                        && !st.sel_len_zero) begin
                    if (st.sel_full) begin
                        cmd.mem_read = 1'b1;
                        state_next   = ST_WRITE;
                    end else begin
                        cmd.push_write = 1'b1;
                    end
                end
            end
            ST_WRITE: begin
                cmd.push_write = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ST_IDLE;
                if (st.last && seen_reg) begin
                    seen_next = 1'b0;
                    if (st.both_full) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = 1'b0;
                        step_next     = '0;
                        state_next    = ST_DIV_A;
                    end
                end
            end
            ST_DIV_A: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUOT_W - 1)) begin
                    state_next = ST_SWITCH;
                end
            end
            ST_SWITCH: begin
                cmd.save_audio = 1'b1;
                cmd.div_start  = 1'b1;
                cmd.div_sel    = 1'b1;
                step_next      = '0;
                state_next     = ST_DIV_V;
            end
            ST_DIV_V: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUOT_W - 1)) begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE: begin
                cmd.save_video = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_result = 1'b1;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seen_reg     <= 1'b0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### hdl/lwqc_dp.sv
// datapath: config registers, loss windows with sample memory, serial divider, result register
`timescale 1ns / 1ps

module lwqc_dp import lwqc_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [S_USER_W-1:0]   s_tuser,
    input  logic                  s_tlast,
    input  dp_cmd_t               cmd,
    output dp_status_t            st,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int HEAD_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W     = $clog2(MAX_WINDOW * 255 + 1);
    localparam int MEM_DEPTH = 2 << HEAD_W;

    // item
    logic [1:0]            kind_reg;
    logic [7:0]            diff_reg;
    logic                  last_reg;

    // window state, index 0 audio, 1 video
    logic [1:0][CNT_W-1:0]  len_reg;
    logic [1:0][CNT_W-1:0]  count_reg;
    logic [1:0][HEAD_W-1:0] head_reg;
    logic [1:0][SUM_W-1:0]  sum_reg;

    logic [7:0] a_high_reg, a_low_reg, v_high_reg, v_low_reg;

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        rd_data_reg;

    // divider
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [QUOT_W-1:0] quo_reg;
    logic [7:0]        mean_a_reg, mean_v_reg;

    logic [1:0]          level_reg;
    logic [M_DATA_W-1:0] res_reg;

    logic              w;
    logic [CNT_W-1:0]  sel_len, sel_cnt, cnt_inc, head_inc, len_clamp;
    logic [HEAD_W-1:0] sel_head, wr_idx, head_next;
    logic [SUM_W-1:0]  sel_sum, sum_next, div_sum;
    logic              sel_full;
    logic [CNT_W:0]    shifted;
    logic              ge;
    logic [1:0]        la, lv, level;

    function automatic logic [1:0] classify(input logic [7:0] mean,
                                            input logic [7:0] hi,
                                            input logic [7:0] lo);
        logic [1:0] r;
        if (mean >= hi) begin
            r = LEVEL_HIGH;
        end else if (mean >= lo) begin
            r = LEVEL_LOW;
        end else begin
            r = LEVEL_GOOD;
        end
        return r;
    endfunction

    assign w        = (kind_reg == KIND_VIDEO);
    assign sel_len  = w ? len_reg[1]   : len_reg[0];
    assign sel_cnt  = w ? count_reg[1] : count_reg[0];
    assign sel_head = w ? head_reg[1]  : head_reg[0];
    assign sel_sum  = w ? sum_reg[1]   : sum_reg[0];
    assign sel_full = (sel_cnt == sel_len);

    assign st.item_kind    = kind_reg;
    assign st.last         = last_reg;
    assign st.sel_len_zero = (sel_len == '0);
    assign st.sel_full     = sel_full;
    assign st.both_full    = (count_reg[0] == len_reg[0]) && (count_reg[1] == len_reg[1]);

    assign cnt_inc   = sel_cnt + CNT_W'(1);
    assign head_inc  = CNT_W'(sel_head) + CNT_W'(1);
    assign head_next = (head_inc == sel_len) ? '0 : HEAD_W'(head_inc);
    assign wr_idx    = sel_full ? sel_head : HEAD_W'(sel_cnt);
    assign sum_next  = sel_full ? (sel_sum - SUM_W'(rd_data_reg) + SUM_W'(diff_reg))
                                : (sel_sum + SUM_W'(diff_reg));

    assign len_clamp = (32'(cfg_wdata[6:0]) > 32'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                               : CNT_W'(cfg_wdata[6:0]);

    assign div_sum = cmd.div_sel ? sum_reg[1] : sum_reg[0];
    assign shifted = {rem_reg, quo_reg[QUOT_W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    assign la    = classify(mean_a_reg, a_high_reg, a_low_reg);
    assign lv    = classify(mean_v_reg, v_high_reg, v_low_reg);
    assign level = (la < lv) ? la : lv;

    assign m_tdata = res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= s_tuser;
            diff_reg <= (s_tdata[7:0] >= s_tdata[15:8]) ? (s_tdata[7:0] - s_tdata[15:8]) : 8'd0;
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            rd_data_reg <= mem[{w, sel_head}];
        end
        if (cmd.push_write) begin
            mem[{w, wr_idx}] <= diff_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= {CNT_W'(1), CNT_W'(1)};
            count_reg  <= '0;
            head_reg   <= '0;
            sum_reg    <= '0;
            a_high_reg <= 8'd20;
            a_low_reg  <= 8'd10;
            v_high_reg <= 8'd20;
            v_low_reg  <= 8'd10;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_AUDIO_LEN: begin
                        if (len_clamp != len_reg[0]) begin
                            len_reg[0]   <= len_clamp;
                            count_reg[0] <= '0;
                            head_reg[0]  <= '0;
                            sum_reg[0]   <= '0;
                        end
                    end
                    REG_VIDEO_LEN: begin
                        if (len_clamp != len_reg[1]) begin
                            len_reg[1]   <= len_clamp;
                            count_reg[1] <= '0;
                            head_reg[1]  <= '0;
                            sum_reg[1]   <= '0;
                        end
                    end
                    REG_AUDIO_HIGH_TH: a_high_reg <= cfg_wdata;
                    REG_AUDIO_LOW_TH:  a_low_reg  <= cfg_wdata;
                    REG_VIDEO_HIGH_TH: v_high_reg <= cfg_wdata;
                    REG_VIDEO_LOW_TH:  v_low_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd.push_write) begin
                sum_reg[w] <= sum_next;
                if (sel_full) begin
                    head_reg[w] <= head_next;
                end else begin
                    count_reg[w] <= cnt_inc;
                end
            end
        end
    end

    // restoring divider, sum < 256 * count so the quotient fits 8 bits
    always_ff @(posedge aclk) begin
        if (cmd.save_audio) begin
            mean_a_reg <= (count_reg[0] == '0) ? 8'd0 : quo_reg;
        end
        if (cmd.save_video) begin
            mean_v_reg <= (count_reg[1] == '0) ? 8'd0 : quo_reg;
        end
        if (cmd.div_start) begin
            dvs_reg <= cmd.div_sel ? count_reg[1] : count_reg[0];
            rem_reg <= CNT_W'(div_sum >> QUOT_W);
            quo_reg <= div_sum[QUOT_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= ge ? CNT_W'(shifted - {1'b0, dvs_reg}) : CNT_W'(shifted);
            quo_reg <= {quo_reg[QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_GOOD;
        end else if (cmd.load_result) begin
            level_reg <= level;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            res_reg <= {4'b0000, mean_v_reg, mean_a_reg,
                        (mean_a_reg != 8'd0) || (mean_v_reg != 8'd0),
                        level != level_reg, level};
        end
    end

endmodule
